// ===== sv/sip_pkg.sv =====
package sip_pkg;

   localparam int VALUE_W  = 32;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 3;

   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_PROBE = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   localparam logic [STATUS_W-1:0] ST_LOADED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_MATCH   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_MISS    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd4;

   typedef struct packed {
      logic                       vld;
      logic [STATUS_W-1:0]        status;
      logic signed [VALUE_W-1:0]  value;
      logic                       last;
   } word_type;

endpackage

// ===== sv/sip_head.sv =====
module sip_head import sip_pkg::*; #(
   parameter int SET_DEPTH = 64,
   parameter int CW        = 7
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      req_valid,
   input  logic [OP_W-1:0]           req_op,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      req_last_probe,
   output word_type                  dn_word,
   output logic [CW-1:0]             dn_slot
);

   localparam logic [CW-1:0] DEPTH_C = CW'(SET_DEPTH);

   logic [CW-1:0] count_ff, count_in;
   word_type      word_ff, word_in;
   logic [CW-1:0] slot_ff;
   logic          accept;

   assign accept = req_valid && advance;

   always_comb begin
      count_in       = count_ff;
      word_in.vld    = accept;
      word_in.status = ST_MISS;
      word_in.value  = req_value;
      word_in.last   = 1'b0;
      unique case (req_op)
         OP_LOAD: begin
            if (count_ff < DEPTH_C) begin
               word_in.status = ST_LOADED;
               if (accept) begin
                  count_in = count_ff + CW'(1);
               end
            end else begin
               word_in.status = ST_FULL;
            end
         end
         OP_PROBE: begin
            word_in.status = ST_MISS;
            word_in.last   = req_last_probe;
         end
         OP_CLEAR: begin
            word_in.status = ST_CLEARED;
            if (accept) begin
               count_in = '0;
            end
         end
         default: begin
            word_in.vld = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         word_ff.vld <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (advance) begin
            word_ff <= word_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         slot_ff <= count_ff;
      end
   end

   assign dn_word = word_ff;
   assign dn_slot = slot_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("entry count above depth");
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      accept && req_op == OP_CLEAR |=> count_ff == '0)
      else $error("clear did not empty the set");
   a_load_grows: assert property (@(posedge clock) disable iff (reset)
      accept && req_op == OP_LOAD && count_ff < DEPTH_C
      |=> count_ff == $past(count_ff) + CW'(1))
      else $error("load did not advance the count");
   a_probe_holds: assert property (@(posedge clock) disable iff (reset)
      accept && req_op == OP_PROBE |=> count_ff == $past(count_ff))
      else $error("probe changed the count");
`endif

endmodule

// ===== sv/sip_cell.sv =====
module sip_cell import sip_pkg::*; #(
   parameter int CW    = 7,
   parameter int INDEX = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  word_type      up_word,
   input  logic [CW-1:0] up_slot,
   output word_type      dn_word,
   output logic [CW-1:0] dn_slot
);

   localparam logic [CW-1:0] MY_SLOT = CW'(INDEX);

   logic signed [VALUE_W-1:0] entry_ff;
   word_type                  word_ff, word_in;
   logic [CW-1:0]             slot_ff;
   logic                      wr, probe, hit;

   always_comb begin
      wr      = up_word.vld && up_word.status == ST_LOADED && up_slot == MY_SLOT;
      probe   = up_word.vld && (up_word.status == ST_MISS || up_word.status == ST_MATCH);
      hit     = probe && MY_SLOT < up_slot && entry_ff == up_word.value;
      word_in = up_word;
      if (hit) begin
         word_in.status = ST_MATCH;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && wr) begin
         entry_ff <= up_word.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.vld <= 1'b0;
      end else if (advance) begin
         word_ff <= word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         slot_ff <= up_slot;
      end
   end

   assign dn_word = word_ff;
   assign dn_slot = slot_ff;

endmodule

// ===== sv/set_intersection_probe_top.sv =====
// Membership probe of a streamed array against a stored reference set of up to SET_DEPTH
// signed 32-bit values. Items (load, probe, clear) travel in order down a chain of
// SET_DEPTH cells, one cell per cycle unless the result side stalls, each cell holding
// one set entry: a load is written by the cell whose slot it targets, a probe picks up a
// match in any cell below the fill count it saw on entry. One item is taken every cycle
// unless a stall on the result side freezes the whole chain; each result passes the head
// register and every cell. Op 3 is taken and gives no result. No clearing pass after reset.
module set_intersection_probe_top import sip_pkg::*; #(
   parameter int SET_DEPTH = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [OP_W-1:0]            req_op,
   input  logic signed [VALUE_W-1:0]  req_value,
   input  logic                       req_last_probe,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [VALUE_W-1:0]  rsp_echo_value,
   output logic                       rsp_last_of_run
);

   localparam int CW = $clog2(SET_DEPTH + 1);

   word_type      chain_word [SET_DEPTH+1];
   logic [CW-1:0] chain_slot [SET_DEPTH+1];
   logic          advance;

   assign advance   = !chain_word[SET_DEPTH].vld || rsp_ready;
   assign req_ready = advance;

   sip_head #(
      .SET_DEPTH (SET_DEPTH),
      .CW        (CW)
   ) u_head (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .req_valid      (req_valid),
      .req_op         (req_op),
      .req_value      (req_value),
      .req_last_probe (req_last_probe),
      .dn_word        (chain_word[0]),
      .dn_slot        (chain_slot[0])
   );

   for (genvar k = 0; k < SET_DEPTH; k++) begin : g_cell
      sip_cell #(
         .CW    (CW),
         .INDEX (k)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .up_word (chain_word[k]),
         .up_slot (chain_slot[k]),
         .dn_word (chain_word[k+1]),
         .dn_slot (chain_slot[k+1])
      );
   end

   assign rsp_valid       = chain_word[SET_DEPTH].vld;
   assign rsp_status      = chain_word[SET_DEPTH].status;
   assign rsp_echo_value  = chain_word[SET_DEPTH].value;
   assign rsp_last_of_run = chain_word[SET_DEPTH].last;

`ifndef ASSERT_OFF
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_CLEARED)
      else $error("result status out of range");
   a_last_probe_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_run |-> rsp_status == ST_MATCH || rsp_status == ST_MISS)
      else $error("last mark on a non-probe word");
   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      chain_word[SET_DEPTH].vld |-> chain_slot[SET_DEPTH] <= CW'(SET_DEPTH))
      else $error("slot index above depth");
`endif

endmodule

// ===== tb/sv/probe_result_checker.sv =====
module probe_result_checker import sip_pkg::*; #(
   parameter int SET_DEPTH = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [OP_W-1:0]            req_op,
   input  logic signed [VALUE_W-1:0]  req_value,
   input  logic                       req_last_probe,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [STATUS_W-1:0]        rsp_status,
   input  logic signed [VALUE_W-1:0]  rsp_echo_value,
   input  logic                       rsp_last_of_run,
   output int                         fail_count,
   output int                         pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  value;
      logic                last;
   } probe_answer_type;

   logic [VALUE_W-1:0] set_copy [SET_DEPTH];
   int unsigned        set_fill = 0;
   probe_answer_type   owed_answers [$];
   int                 mismatches = 0;

   // updates the local copy of the set and returns the answer the block owes
   function automatic probe_answer_type answer_for(input logic [OP_W-1:0] op,
                                                   input logic [VALUE_W-1:0] v,
                                                   input logic mark);
      probe_answer_type a;
      a.value  = v;
      a.last   = 1'b0;
      a.status = ST_LOADED;
      case (op)
         OP_LOAD: begin
            if (set_fill < SET_DEPTH) begin
               set_copy[set_fill] = v;
               set_fill++;
            end else begin
               a.status = ST_FULL;
            end
         end
         OP_PROBE: begin
            a.status = ST_MISS;
            a.last   = mark;
            for (int i = 0; i < set_fill; i++) begin
               if (set_copy[i] == v) a.status = ST_MATCH;
            end
         end
         OP_CLEAR: begin
            set_fill = 0;
            a.status = ST_CLEARED;
         end
         default: ;
      endcase
      return a;
   endfunction

   always @(posedge clock) begin
      probe_answer_type want;
      if (reset) begin
         owed_answers.delete();
         set_fill = 0;
         pending <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (owed_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected word: status %0d value %h last %b",
                           rsp_status, rsp_echo_value, rsp_last_of_run);
            end else begin
               want = owed_answers.pop_front();
               if (want.status !== rsp_status || want.value !== rsp_echo_value ||
                   want.last !== rsp_last_of_run) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: expected status %0d value %h last %b,",
                               " got status %0d value %h last %b"},
                              want.status, want.value, want.last,
                              rsp_status, rsp_echo_value, rsp_last_of_run);
               end
            end
         end
         // words with an unused op are taken but answered with nothing
         if (req_valid && req_ready && (req_op == OP_LOAD || req_op == OP_PROBE ||
                                        req_op == OP_CLEAR))
            owed_answers.push_back(answer_for(req_op, req_value, req_last_probe));
         pending <= owed_answers.size();
      end
      fail_count <= mismatches;
   end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top import sip_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SET_DEPTH = 64;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_WORDS = 850;
   localparam int HOLD_AT = 150;
   localparam int HOLD_LEN = 300;
   localparam int LIMIT = 400000;
   localparam int SETTLE = SET_DEPTH + 16;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [OP_W-1:0]            req_op = OP_LOAD;
   logic signed [VALUE_W-1:0]  req_value = '0;
   logic                       req_last_probe = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [STATUS_W-1:0]        rsp_status;
   logic signed [VALUE_W-1:0]  rsp_echo_value;
   logic                       rsp_last_of_run;

   int                  fail_count;
   int                  pending;
   int                  tx_idle_pct = 10;
   int                  rx_idle_pct = 58;
   int                  words_sent = 0;
   int unsigned         rsp_taken = 0;
   int                  hold_left = 0;
   logic                hold_done = 1'b0;
   int unsigned         cycles = 0;
   logic [VALUE_W-1:0]  loaded_vals [$];

   always #1 clock = ~clock;

   set_intersection_probe_top #(.SET_DEPTH(SET_DEPTH)) i_dut (.*);

   probe_result_checker #(.SET_DEPTH(SET_DEPTH)) i_checker (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("FAIL set_intersection_probe_top");
         $finish;
      end
   end

   // receiver, with one long hold-off so the cell chain fills up
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) rsp_taken <= rsp_taken + 1;
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (rsp_taken == HOLD_AT && !hold_done) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   task automatic send_word(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] v,
                            input logic mark);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < tx_idle_pct) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_value      <= v;
      req_last_probe <= mark;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (op != OP_UNUSED) words_sent++;
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(3))
         0: return 32'($urandom_range(15)) - 32'd8;
         1: return $urandom_range(1) ? (32'h8000_0000 | 32'($urandom_range(3)))
                                     : (32'h7fff_fffc | 32'($urandom_range(3)));
         default: return $urandom();
      endcase
   endfunction

   // clear (in most rounds), load a set, then probe it as one array, now and then followed by random words
   task automatic set_round();
      int                 n_load;
      int                 n_probe;
      logic [VALUE_W-1:0] v;
      if ($urandom_range(9) < 8) begin
         send_word(OP_CLEAR, pick_value(), 1'($urandom_range(1)));
         loaded_vals.delete();
      end
      n_load = ($urandom_range(5) == 0) ? $urandom_range(70, 60) : $urandom_range(12);
      repeat (n_load) begin
         v = pick_value();
         send_word(OP_LOAD, v, 1'($urandom_range(1)));
         loaded_vals.push_back(v);
      end
      n_probe = $urandom_range(20, 1);
      for (int i = 1; i <= n_probe; i++) begin
         if (loaded_vals.size() != 0 && $urandom_range(9) < 7) begin
            v = loaded_vals[$urandom_range(loaded_vals.size() - 1)];
            if ($urandom_range(3) == 0) v[VALUE_W-1] = ~v[VALUE_W-1];
         end else begin
            v = pick_value();
         end
         send_word(OP_PROBE, v, i == n_probe);
      end
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(4, 1))
            send_word(OP_W'($urandom_range(3)), $urandom(), 1'($urandom_range(1)));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty set, extremes, duplicates, sign bit, ignored op and mark
      send_word(OP_PROBE, 32'h0000_0005, 1'b1);
      send_word(OP_UNUSED, 32'h1234_5678, 1'b0);
      send_word(OP_LOAD, 32'h7fff_ffff, 1'b1);
      send_word(OP_LOAD, 32'h8000_0000, 1'b0);
      send_word(OP_LOAD, 32'h0000_0000, 1'b0);
      send_word(OP_LOAD, 32'hffff_ffff, 1'b0);
      send_word(OP_LOAD, 32'h7fff_ffff, 1'b0);
      send_word(OP_LOAD, 32'h0000_1234, 1'b0);
      send_word(OP_PROBE, 32'h7fff_ffff, 1'b0);
      send_word(OP_PROBE, 32'hffff_ffff, 1'b0);
      send_word(OP_PROBE, 32'h7fff_fffe, 1'b0);
      send_word(OP_PROBE, 32'h0000_0000, 1'b0);
      send_word(OP_PROBE, 32'h8000_0000, 1'b0);
      send_word(OP_PROBE, 32'h8000_1234, 1'b0);
      send_word(OP_PROBE, 32'h0000_1234, 1'b1);
      send_word(OP_UNUSED, 32'hffff_ffff, 1'b1);
      send_word(OP_CLEAR, 32'h8000_0000, 1'b1);
      send_word(OP_PROBE, 32'h0000_0000, 1'b0);
      send_word(OP_PROBE, 32'h7fff_ffff, 1'b1);
      drain_all();

      words_sent = 0;
      while (words_sent < RANDOM_WORDS) begin
         if (words_sent >= 2 * RANDOM_WORDS / 3) begin
            tx_idle_pct <= 0;
            rx_idle_pct <= 0;
         end else if (words_sent >= RANDOM_WORDS / 3) begin
            tx_idle_pct <= 58;
            rx_idle_pct <= 10;
         end
         set_round();
         if (words_sent >= RANDOM_WORDS / 3 && $urandom_range(7) == 0) drain_all();
      end

      drain_all();
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS set_intersection_probe_top");
      end else begin
         $display("FAIL set_intersection_probe_top");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/sip_pkg.sv
sv/sip_head.sv
sv/sip_cell.sv
sv/set_intersection_probe_top.sv
tb/sv/probe_result_checker.sv
tb/sv/tb_top.sv
